// ----- sv/boc_pkg.sv -----
package boc_pkg;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_CARVE_MODE    = 3'd0,
		REG_OPENING_LO_U  = 3'd1,
		REG_OPENING_HI_U  = 3'd2,
		REG_OPENING_LO_Y  = 3'd3,
		REG_OPENING_HI_Y  = 3'd4,
		REG_MIN_THICKNESS = 3'd5
	} reg_index_t;

	localparam logic [1:0] MODE_ALONG_X = 2'd0;
	localparam logic [1:0] MODE_ALONG_Z = 2'd1;
	localparam logic [1:0] MODE_PASS    = 2'd2;

	localparam logic [15:0] MIN_THICKNESS_RESET = 16'd66;

	typedef struct packed {
		logic [1:0]  carve_mode;
		logic [31:0] opening_lo_u;
		logic [31:0] opening_hi_u;
		logic [31:0] opening_lo_y;
		logic [31:0] opening_hi_y;
		logic [15:0] min_thickness;
	} cfg_t;

	// Axis order inside the corner arrays is x, y, z.
	typedef struct packed {
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
	} box_t;

	typedef struct packed {
		box_t        box;
		logic [31:0] ov_lu;
		logic [31:0] ov_hu;
		logic [31:0] ov_ly;
		logic [31:0] ov_hy;
		logic        axis_z;
		logic        pass;
		logic [3:0]  keep;
	} entry_t;

	// Builds strip idx (left, right, below, above) of a carved box.
	function automatic box_t strip_box(entry_t e, logic [1:0] idx);
		box_t       s;
		logic [1:0] u;
		s = e.box;
		u = e.axis_z ? 2'd2 : 2'd0;
		unique case (idx)
			2'd0: begin
				s.hi[u] = e.ov_lu;
			end
			2'd1: begin
				s.lo[u] = e.ov_hu;
			end
			2'd2: begin
				s.lo[u] = e.ov_lu;
				s.hi[u] = e.ov_hu;
				s.hi[1] = e.ov_ly;
			end
			default: begin
				s.lo[u] = e.ov_lu;
				s.hi[u] = e.ov_hu;
				s.lo[1] = e.ov_hy;
			end
		endcase
		return s;
	endfunction

	// True when every extent is strictly above the minimum thickness.
	function automatic logic thick_enough(box_t b, logic [15:0] mt);
		logic signed [32:0] ext;
		logic               ok;
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			ext = $signed({b.hi[a][31], b.hi[a]}) - $signed({b.lo[a][31], b.lo[a]});
			if (!(ext > $signed({17'd0, mt}))) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

// ----- sv/boc_front.sv -----
module boc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  boc_pkg::cfg_t     cfg,
	input  logic              push,
	output logic              full,
	input  boc_pkg::box_t     box,
	output logic              q_push,
	output boc_pkg::entry_t   q_entry,
	input  logic              q_ready
);

	logic            s1_valid_q;
	boc_pkg::box_t   box_s1;
	logic            s2_valid_q;
	boc_pkg::entry_t entry_s2;

	logic            s1_free;
	logic            s2_free;
	logic            s1_adv;
	logic [1:0]      u;
	logic [31:0]     box_lo_u;
	logic [31:0]     box_hi_u;
	boc_pkg::entry_t entry_c;

	assign s2_free = !s2_valid_q || q_ready;
	assign s1_adv  = s1_valid_q && s2_free;
	assign s1_free = !s1_valid_q || s2_free;
	assign full    = !s1_free;

	// Stage one: overlap of the box with the opening.
	always_comb begin
		u        = (cfg.carve_mode == boc_pkg::MODE_ALONG_Z) ? 2'd2 : 2'd0;
		box_lo_u = box_s1.lo[u];
		box_hi_u = box_s1.hi[u];
		entry_c        = '0;
		entry_c.box    = box_s1;
		entry_c.axis_z = (cfg.carve_mode == boc_pkg::MODE_ALONG_Z);
		entry_c.ov_lu  = ($signed(box_lo_u) > $signed(cfg.opening_lo_u)) ?
			box_lo_u : cfg.opening_lo_u;
		entry_c.ov_hu  = ($signed(box_hi_u) < $signed(cfg.opening_hi_u)) ?
			box_hi_u : cfg.opening_hi_u;
		entry_c.ov_ly  = ($signed(box_s1.lo[1]) > $signed(cfg.opening_lo_y)) ?
			box_s1.lo[1] : cfg.opening_lo_y;
		entry_c.ov_hy  = ($signed(box_s1.hi[1]) < $signed(cfg.opening_hi_y)) ?
			box_s1.hi[1] : cfg.opening_hi_y;
		// Modes two and three never carve.
		entry_c.pass   = cfg.carve_mode[1] ||
			!($signed(entry_c.ov_lu) < $signed(entry_c.ov_hu)) ||
			!($signed(entry_c.ov_ly) < $signed(entry_c.ov_hy));
	end

	// Stage two: thickness test of the four strips; a pass entry keeps only the whole box.
	always_comb begin
		q_entry = entry_s2;
		if (entry_s2.pass) begin
			q_entry.keep = 4'b0001;
		end else begin
			for (int s = 0; s < 4; s++) begin
				q_entry.keep[s] = boc_pkg::thick_enough(
					boc_pkg::strip_box(entry_s2, 2'(s)), cfg.min_thickness);
			end
		end
	end

	assign q_push = s2_valid_q && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= push;
			end
			if (s2_free) begin
				s2_valid_q <= s1_adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && s1_free) begin
			box_s1 <= box;
		end
		if (s1_adv) begin
			entry_s2 <= entry_c;
		end
	end

endmodule

// ----- sv/boc_queue.sv -----
module boc_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  boc_pkg::entry_t   wr_entry,
	output logic              ready,
	output logic              head_valid,
	output boc_pkg::entry_t   head,
	input  logic              pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	boc_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign ready      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ----- sv/boc_back.sv -----
module boc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  boc_pkg::entry_t   head,
	output logic              head_pop,
	output logic              empty,
	input  logic              pop,
	output boc_pkg::box_t     out_box,
	output logic              final_piece
);

	logic [3:0]    done_q;
	logic          out_valid_q;
	boc_pkg::box_t out_box_q;
	logic          final_q;

	logic [3:0]    rem;
	logic [3:0]    pick;
	logic [3:0]    rest;
	logic [1:0]    idx;
	logic          out_free;
	logic          emit;
	logic          drop;

	always_comb begin
		rem  = head.keep & ~done_q;
		pick = rem & (~rem + 4'd1);
		rest = rem & ~pick;
		if (rem[0]) begin
			idx = 2'd0;
		end else if (rem[1]) begin
			idx = 2'd1;
		end else if (rem[2]) begin
			idx = 2'd2;
		end else begin
			idx = 2'd3;
		end
	end

	assign out_free = !out_valid_q || pop;
	assign emit     = head_valid && (rem != 4'd0) && out_free;
	// An item whose strips are all too thin leaves the queue with no result.
	assign drop     = head_valid && (rem == 4'd0);
	assign head_pop = drop || (emit && (rest == 4'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | pick;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_box_q <= head.pass ? head.box : boc_pkg::strip_box(head, idx);
			final_q   <= (rest == 4'd0);
		end
	end

	assign empty       = !out_valid_q;
	assign out_box     = out_box_q;
	assign final_piece = final_q;

endmodule

// ----- sv/box_opening_carver_unit.sv -----
// An accepted box passes stage one, stage two and the queue before the output register holds a result.
// Throughput: the front takes one box per cycle while full is low; the result side gives one box per
// cycle while pop frees the output, so an item holds the back end until all its strips are given.
// A queue of QUEUE_DEPTH classified boxes sits between the front pipeline and the strip emitter.
// Reset (arst_n low, asynchronous) empties all stages and the queue and sets carve_mode to 2,
// the opening edges to 0 and min_thickness to 66.
module box_opening_carver_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [31:0] in_min_x,
	input  logic [31:0] in_min_y,
	input  logic [31:0] in_min_z,
	input  logic [31:0] in_max_x,
	input  logic [31:0] in_max_y,
	input  logic [31:0] in_max_z,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] out_min_x,
	output logic [31:0] out_min_y,
	output logic [31:0] out_min_z,
	output logic [31:0] out_max_x,
	output logic [31:0] out_max_y,
	output logic [31:0] out_max_z,
	output logic        final_piece
);

	boc_pkg::cfg_t   cfg_q;
	boc_pkg::box_t   in_box;
	boc_pkg::box_t   out_box;
	boc_pkg::entry_t q_wr_entry;
	boc_pkg::entry_t q_head;
	logic            q_push;
	logic            q_ready;
	logic            q_head_valid;
	logic            q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carve_mode    <= boc_pkg::MODE_PASS;
			cfg_q.opening_lo_u  <= '0;
			cfg_q.opening_hi_u  <= '0;
			cfg_q.opening_lo_y  <= '0;
			cfg_q.opening_hi_y  <= '0;
			cfg_q.min_thickness <= boc_pkg::MIN_THICKNESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				boc_pkg::REG_CARVE_MODE:    cfg_q.carve_mode    <= cfg_wdata[1:0];
				boc_pkg::REG_OPENING_LO_U:  cfg_q.opening_lo_u  <= cfg_wdata;
				boc_pkg::REG_OPENING_HI_U:  cfg_q.opening_hi_u  <= cfg_wdata;
				boc_pkg::REG_OPENING_LO_Y:  cfg_q.opening_lo_y  <= cfg_wdata;
				boc_pkg::REG_OPENING_HI_Y:  cfg_q.opening_hi_y  <= cfg_wdata;
				boc_pkg::REG_MIN_THICKNESS: cfg_q.min_thickness <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		in_box.lo[0] = in_min_x;
		in_box.lo[1] = in_min_y;
		in_box.lo[2] = in_min_z;
		in_box.hi[0] = in_max_x;
		in_box.hi[1] = in_max_y;
		in_box.hi[2] = in_max_z;
	end

	boc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.box     (in_box),
		.q_push  (q_push),
		.q_entry (q_wr_entry),
		.q_ready (q_ready)
	);

	boc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_entry   (q_wr_entry),
		.ready      (q_ready),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	boc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.head        (q_head),
		.head_pop    (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_box     (out_box),
		.final_piece (final_piece)
	);

	assign out_min_x = out_box.lo[0];
	assign out_min_y = out_box.lo[1];
	assign out_min_z = out_box.lo[2];
	assign out_max_x = out_box.hi[0];
	assign out_max_y = out_box.hi[1];
	assign out_max_z = out_box.hi[2];

endmodule
